### src/bba_pkg.sv
package bba_pkg;

  // Default tree depth and stored size width
  localparam int LEVELS_DEF    = 10;
  localparam int SIZE_BITS_DEF = 21;

  // Fixed widths of the channel and configuration fields
  localparam int IN_SIZE_W  = 21;
  localparam int OUT_NODE_W = 11;
  localparam int STATUS_W   = 2;
  localparam int MARK_W     = 2;

  localparam logic [IN_SIZE_W-1:0] TOTAL_SIZE_RST = 21'd1024;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NOMEM    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_ZERO     = 2'd3
  } bba_status_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_LEVEL,
    ST_CAND_RD,
    ST_CAND_CHK,
    ST_ANC_CHK,
    ST_ALLOC_WR,
    ST_DIV_WR,
    ST_FSCAN,
    ST_FREE_WR,
    ST_MERGE_RD,
    ST_MERGE_CHK,
    ST_DONE
  } bba_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic        clr_step;
    logic        load;
    logic        lvl_inc;
    logic        cand_first;
    logic        cand_inc;
    logic        cand_skip;
    logic        rd_cand;
    logic        anc_from_cand;
    logic        anc_up;
    logic        wr_alloc;
    logic        wr_div;
    logic        scan_init;
    logic        scan_step;
    logic        wr_found;
    logic        rd_buddy;
    logic        wr_merge;
    logic        finish;
    bba_status_t code;
    logic        emit;
  } bba_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic req_zero;
    logic req_big;
    logic kind_free;
    logic lvl_more;
    logic cand_end;
    logic cand_root;
    logic anc_root;
    logic rd_free;
    logic rd_alloc;
    logic scan_hit;
    logic scan_last;
    logic out_busy;
  } bba_stat_t;

endpackage

### src/bba_req_if.sv
interface bba_req_if;
  import bba_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [IN_SIZE_W-1:0] size;

  modport source (output valid, output kind, output size, input ready);
  modport sink (input valid, input kind, input size, output ready);
endinterface

### src/bba_rsp_if.sv
interface bba_rsp_if;
  import bba_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [OUT_NODE_W-1:0] node_index;

  modport source (output valid, output status, output node_index, input ready);
  modport sink (input valid, input status, input node_index, output ready);
endinterface

### src/buddy_block_allocator.sv
// Buddy allocator over a complete binary tree of 2^(LEVELS+1)-1 nodes held in
// one node table with a single access a cycle (a write or a registered read).
// After reset the block runs a clearing pass over all 2^(LEVELS+1)-1 nodes
// with in_chan.ready low; cfg writes are taken meanwhile.
// One request is worked on at a time and gives one result; the result sits in
// an output register, so the next request is taken while it waits.
// A result can wait for the previous result to leave the output register. An
// allocate picks its level from the size, then reads the nodes on that level
// in index order and, for a free one, reads one ancestor at a time up the
// tree; a blocked ancestor skips its whole subtree. A free scans the table one
// node a cycle in index order, then merges free buddies up the tree. Zero-size
// requests and oversize allocates are answered from the decode step.
module buddy_block_allocator #(
  parameter int LEVELS    = bba_pkg::LEVELS_DEF,
  parameter int SIZE_BITS = bba_pkg::SIZE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bba_pkg::IN_SIZE_W-1:0] cfg_wr_data,
  bba_req_if.sink                       in_chan,
  bba_rsp_if.source                     out_chan
);
  import bba_pkg::*;

  bba_cmd_t  cmd;
  bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_datapath #(
    .LEVELS    (LEVELS),
    .SIZE_BITS (SIZE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_kind        (in_chan.kind),
    .in_size        (in_chan.size),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .out_status     (out_chan.status),
    .out_node_index (out_chan.node_index),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

### src/bba_ctrl.sv
module bba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bba_pkg::bba_stat_t stat,
  output bba_pkg::bba_cmd_t  cmd
);
  import bba_pkg::*;

  bba_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:     if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:      if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        if (stat.req_zero)       state_nxt = ST_DONE;
        else if (stat.kind_free) state_nxt = ST_FSCAN;
        else if (stat.req_big)   state_nxt = ST_DONE;
        else                     state_nxt = ST_LEVEL;
      end
      ST_LEVEL:     if (!stat.lvl_more) state_nxt = ST_CAND_RD;
      ST_CAND_RD:   state_nxt = stat.cand_end ? ST_DONE : ST_CAND_CHK;
      ST_CAND_CHK: begin
        if (!stat.rd_free)      state_nxt = ST_CAND_RD;
        else if (stat.cand_root) state_nxt = ST_ALLOC_WR;
        else                     state_nxt = ST_ANC_CHK;
      end
      ST_ANC_CHK: begin
        if (stat.rd_alloc)      state_nxt = ST_CAND_RD;
        else if (stat.anc_root) state_nxt = ST_ALLOC_WR;
      end
      ST_ALLOC_WR:  state_nxt = ST_DIV_WR;
      ST_DIV_WR:    if (stat.anc_root) state_nxt = ST_DONE;
      ST_FSCAN: begin
        if (stat.scan_hit)       state_nxt = ST_FREE_WR;
        else if (stat.scan_last) state_nxt = ST_DONE;
      end
      ST_FREE_WR:   state_nxt = ST_MERGE_RD;
      ST_MERGE_RD:  state_nxt = stat.anc_root ? ST_DONE : ST_MERGE_CHK;
      ST_MERGE_CHK: state_nxt = stat.rd_free ? ST_MERGE_RD : ST_DONE;
      ST_DONE:      if (!stat.out_busy) state_nxt = ST_IDLE;
      default:      state_nxt = ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.code = STAT_OK;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECODE: begin
        if (stat.req_zero) begin
          cmd.finish = 1'b1;
          cmd.code   = STAT_ZERO;
        end else if (stat.kind_free) begin
          cmd.scan_init = 1'b1;
        end else if (stat.req_big) begin
          cmd.finish = 1'b1;
          cmd.code   = STAT_NOMEM;
        end
      end
      ST_LEVEL: begin
        if (stat.lvl_more) cmd.lvl_inc = 1'b1;
        else               cmd.cand_first = 1'b1;
      end
      ST_CAND_RD: begin
        if (stat.cand_end) begin
          cmd.finish = 1'b1;
          cmd.code   = STAT_NOMEM;
        end else begin
          cmd.rd_cand = 1'b1;
        end
      end
      ST_CAND_CHK: begin
        if (!stat.rd_free)       cmd.cand_inc = 1'b1;
        else if (!stat.cand_root) cmd.anc_from_cand = 1'b1;
      end
      ST_ANC_CHK: begin
        if (stat.rd_alloc)       cmd.cand_skip = 1'b1;
        else if (!stat.anc_root) cmd.anc_up = 1'b1;
      end
      ST_ALLOC_WR: cmd.wr_alloc = 1'b1;
      ST_DIV_WR: begin
        if (stat.anc_root) cmd.finish = 1'b1;
        else               cmd.wr_div = 1'b1;
      end
      ST_FSCAN: begin
        if (stat.scan_hit) begin
          // hold the scan pointer on the match
        end else if (stat.scan_last) begin
          cmd.finish = 1'b1;
          cmd.code   = STAT_NOTFOUND;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FREE_WR: cmd.wr_found = 1'b1;
      ST_MERGE_RD: begin
        if (stat.anc_root) cmd.finish = 1'b1;
        else               cmd.rd_buddy = 1'b1;
      end
      ST_MERGE_CHK: begin
        if (stat.rd_free) cmd.wr_merge = 1'b1;
        else              cmd.finish = 1'b1;
      end
      ST_DONE: cmd.emit = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

### src/bba_datapath.sv
module bba_datapath #(
  parameter int LEVELS    = bba_pkg::LEVELS_DEF,
  parameter int SIZE_BITS = bba_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [bba_pkg::IN_SIZE_W-1:0]    cfg_wr_data,
  input  logic                             in_kind,
  input  logic [bba_pkg::IN_SIZE_W-1:0]    in_size,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [bba_pkg::STATUS_W-1:0]     out_status,
  output logic [bba_pkg::OUT_NODE_W-1:0]   out_node_index,
  input  bba_pkg::bba_cmd_t                cmd,
  output bba_pkg::bba_stat_t               stat
);
  import bba_pkg::*;

  localparam int NW         = LEVELS + 1;
  localparam int LW         = $clog2(LEVELS + 1);
  localparam int MW         = SIZE_BITS + MARK_W;
  localparam int NODE_COUNT = (1 << NW) - 1;
  localparam logic [NW-1:0] NODE_LAST = NW'(NODE_COUNT - 1);
  localparam logic [NW-1:0] NODE_END  = NW'(NODE_COUNT);
  localparam logic [LW-1:0] LVL_MAX   = LW'(LEVELS);
  localparam logic [SIZE_BITS-1:0] TOTAL_RST = SIZE_BITS'(TOTAL_SIZE_RST);

  localparam logic [MARK_W-1:0] MARK_FREE  = 2'd0;
  localparam logic [MARK_W-1:0] MARK_DIV   = 2'd1;
  localparam logic [MARK_W-1:0] MARK_ALLOC = 2'd2;

  // Node table: mark in the top bits, stored size below
  logic [MW-1:0] node_mem [NODE_COUNT];

  logic [SIZE_BITS-1:0] total_r;
  logic                 kind_r;
  logic [SIZE_BITS-1:0] req_r;
  logic [LW-1:0]        level_r;
  logic [LW-1:0]        shift_r;
  logic [NW-1:0]        cand_r, cand_nxt;
  logic [NW-1:0]        anc_r, anc_nxt;
  logic [NW-1:0]        scan_n_r;
  logic                 scan_v_r;
  logic [MW-1:0]        rd_q_r;
  bba_status_t          res_status_r;
  logic [NW-1:0]        res_node_r;
  logic                 out_valid_r;
  bba_status_t          out_status_r;
  logic [OUT_NODE_W-1:0] out_node_r;

  logic [NW-1:0]        cand_par, anc_par, anc_bud;
  logic [NW-1:0]        lvl_first, lvl_end, skip_node;
  logic [NW:0]          skip_wide;
  logic [LW:0]          lvl_shift;
  logic [SIZE_BITS-1:0] total_sh;
  logic [MARK_W-1:0]    rd_mark;
  logic [SIZE_BITS-1:0] rd_size;

  logic                 mem_we, mem_re;
  logic [NW-1:0]        mem_wa, mem_ra;
  logic [MW-1:0]        mem_wd;

  // Tree navigation and level arithmetic
  assign cand_par  = (cand_r - NW'(1)) >> 1;
  assign anc_par   = (anc_r - NW'(1)) >> 1;
  assign anc_bud   = anc_r[0] ? (anc_r + NW'(1)) : (anc_r - NW'(1));
  assign lvl_first = (NW'(1) << level_r) - NW'(1);
  assign lvl_end   = (NW'(2) << level_r) - NW'(1);
  // first node on the level past the blocked ancestor's subtree
  assign skip_wide = (({1'b0, anc_r} + (NW+1)'(2)) << shift_r) - (NW+1)'(1);
  assign skip_node = skip_wide[NW-1:0];
  assign lvl_shift = {1'b0, level_r} + (LW+1)'(1);
  assign total_sh  = total_r >> lvl_shift;
  assign rd_mark   = rd_q_r[MW-1 -: MARK_W];
  assign rd_size   = rd_q_r[SIZE_BITS-1:0];

  // Memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cand_r;
    mem_wd = {MARK_FREE, {SIZE_BITS{1'b0}}};
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.wr_alloc) begin
      mem_we = 1'b1;
      mem_wd = {MARK_ALLOC, req_r};
    end else if (cmd.wr_div) begin
      mem_we = 1'b1;
      mem_wa = anc_par;
      mem_wd = {MARK_DIV, {SIZE_BITS{1'b0}}};
    end else if (cmd.wr_found) begin
      mem_we = 1'b1;
      mem_wa = scan_n_r;
    end else if (cmd.wr_merge) begin
      mem_we = 1'b1;
      mem_wa = anc_par;
    end
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = cand_r;
    if (cmd.rd_cand) begin
      mem_re = 1'b1;
    end else if (cmd.anc_from_cand) begin
      mem_re = 1'b1;
      mem_ra = cand_par;
    end else if (cmd.anc_up) begin
      mem_re = 1'b1;
      mem_ra = anc_par;
    end else if (cmd.scan_step) begin
      mem_re = (cand_r != NODE_END);
    end else if (cmd.rd_buddy) begin
      mem_re = 1'b1;
      mem_ra = anc_bud;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) node_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q_r <= node_mem[mem_ra];
  end

  // Candidate and ancestor pointers
  always_comb begin
    cand_nxt = cand_r;
    if (cmd.clr_step || cmd.cand_inc) begin
      cand_nxt = cand_r + NW'(1);
    end else if (cmd.cand_first) begin
      cand_nxt = lvl_first;
    end else if (cmd.cand_skip) begin
      cand_nxt = skip_node;
    end else if (cmd.scan_init) begin
      cand_nxt = '0;
    end else if (cmd.scan_step && (cand_r != NODE_END)) begin
      cand_nxt = cand_r + NW'(1);
    end else if (cmd.wr_found) begin
      cand_nxt = scan_n_r;
    end
  end

  always_comb begin
    anc_nxt = anc_r;
    if (cmd.anc_from_cand) begin
      anc_nxt = cand_par;
    end else if (cmd.anc_up || cmd.wr_div || cmd.wr_merge) begin
      anc_nxt = anc_par;
    end else if (cmd.wr_alloc) begin
      anc_nxt = cand_r;
    end else if (cmd.wr_found) begin
      anc_nxt = scan_n_r;
    end
  end

  // Control registers; cand_r doubles as the clearing pointer after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r      <= '0;
      scan_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= TOTAL_RST;
    end else begin
      cand_r <= cand_nxt;
      if (cmd.scan_init) begin
        scan_v_r <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_v_r <= (cand_r != NODE_END);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) total_r <= SIZE_BITS'(cfg_wr_data);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    anc_r <= anc_nxt;
    if (cmd.load) begin
      kind_r  <= in_kind;
      req_r   <= SIZE_BITS'(in_size);
      level_r <= '0;
    end else if (cmd.lvl_inc) begin
      level_r <= level_r + LW'(1);
    end
    if (cmd.anc_from_cand) begin
      shift_r <= LW'(1);
    end else if (cmd.anc_up) begin
      shift_r <= shift_r + LW'(1);
    end
    if (cmd.scan_step) scan_n_r <= cand_r;
    if (cmd.finish) begin
      res_status_r <= cmd.code;
      res_node_r   <= (cmd.code == STAT_OK) ? cand_r : '0;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_node_r   <= OUT_NODE_W'(res_node_r);
    end
  end

  // Status towards the controller
  always_comb begin
    stat           = '0;
    stat.clr_last  = (cand_r == NODE_LAST);
    stat.req_zero  = (req_r == '0);
    stat.req_big   = (req_r > total_r);
    stat.kind_free = kind_r;
    stat.lvl_more  = (level_r < LVL_MAX) && (req_r <= total_sh);
    stat.cand_end  = (cand_r >= lvl_end);
    stat.cand_root = (cand_r == '0);
    stat.anc_root  = (anc_r == '0);
    stat.rd_free   = (rd_mark == MARK_FREE);
    stat.rd_alloc  = (rd_mark == MARK_ALLOC);
    stat.scan_hit  = scan_v_r && (rd_mark == MARK_ALLOC) && (rd_size == req_r);
    stat.scan_last = scan_v_r && (scan_n_r == NODE_LAST);
    stat.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_node_index = out_node_r;

endmodule

### src/bba_checker.sv
module bba_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bba_pkg::STATUS_W-1:0]   out_status,
  input logic [bba_pkg::OUT_NODE_W-1:0] out_node_index
);
  import bba_pkg::*;

  // Requests taken whose result has not been transferred yet
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   pend_r <= pend_r + 2'd1;
        2'b01:   pend_r <= pend_r - 2'd1;
        default: pend_r <= pend_r;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_node_index))
    else $error("result changed while stalled");

  a_err_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_node_index == '0)
    else $error("error result carries a node index");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending request");

  a_one_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> pend_r <= 2'd1)
    else $error("request taken with more than one result outstanding");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("request taken before the table was cleared");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_node_index (out_chan.node_index)
);
